[src/sv39_ptw_pkg.sv]
package sv39_ptw_pkg;

   // Field widths
   localparam int VaWidth   = 39;
   localparam int PpnWidth  = 44;
   localparam int PaWidth   = 56;
   localparam int PteWidth  = 64;
   localparam int VpnWidth  = 9;
   localparam int PageShift = 12;

   // Entry flag positions
   localparam int PteBitV = 0;
   localparam int PteBitR = 1;
   localparam int PteBitW = 2;
   localparam int PteBitX = 3;
   localparam int PpnLsb  = 10;

   // Walk levels
   localparam logic [1:0] LevelPage = 2'd0;
   localparam logic [1:0] LevelMega = 2'd1;
   localparam logic [1:0] LevelGiga = 2'd2;

   // Input selector and result kind codes
   localparam logic KindTranslate = 1'b0;
   localparam logic KindResponse  = 1'b1;
   localparam logic ResultRead    = 1'b0;
   localparam logic ResultDone    = 1'b1;

   // Register file: index from paddr bit 3 upward
   localparam int         CsrAddrWidth    = 4;
   localparam logic [0:0] CsrRootTablePpn = 1'd0;

   // Request tdata, last field lowest
   typedef struct packed {
      logic                  pad;
      logic [PteWidth-1:0]   entry_data;
      logic [VaWidth-1:0]    virtual_address;
   } req_data_type;

   // Response tdata, last field lowest
   typedef struct packed {
      logic [4:0]            pad;
      logic                  fault;
      logic [1:0]            leaf_level;
      logic [PteWidth-1:0]   leaf_entry;
      logic [PaWidth-1:0]    physical_address;
      logic [PaWidth-1:0]    read_address;
   } rsp_data_type;

   // Byte address of the entry for one level: table base plus index times 8
   function automatic logic [PaWidth-1:0] entry_address(
      input logic [PpnWidth-1:0] ppn,
      input logic [VaWidth-1:0]  va,
      input logic [1:0]          level
   );
      logic [VpnWidth-1:0] idx;
      case (level)
         LevelPage: idx = va[20:12];
         LevelMega: idx = va[29:21];
         LevelGiga: idx = va[38:30];
         default:   idx = '0;
      endcase
      return {ppn, idx, 3'b000};
   endfunction

   // Leaf physical address: PPN shifted up, page offset ORed in
   function automatic logic [PaWidth-1:0] leaf_address(
      input logic [PpnWidth-1:0] ppn,
      input logic [VaWidth-1:0]  va,
      input logic [1:0]          level
   );
      logic [VaWidth-1:0] off;
      case (level)
         LevelPage: off = {27'd0, va[11:0]};
         LevelMega: off = {18'd0, va[20:0]};
         LevelGiga: off = {9'd0, va[29:0]};
         default:   off = va;
      endcase
      return {ppn, {PageShift{1'b0}}} | {{(PaWidth-VaWidth){1'b0}}, off};
   endfunction

endpackage

[src/sv39_page_table_walker_top.sv]
// Sv39 page table walker.
// Path: input register, decision stage, result register, then out on rsp_tvalid.
// Throughput: one transaction per cycle unless the result side stalls; the single
// decision stage between the input and result registers sets that figure.
// Reset (synchronous): walker idle, level 2, root table PPN 0, no pending data.
module sv39_page_table_walker_top (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // virtual_address[38:0], entry_data[102:39], zero pad
   input  logic [0:0]   req_tuser,   // kind
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [183:0] rsp_tdata,   // read_address[55:0], physical_address[111:56],
                                     // leaf_entry[175:112], leaf_level[177:176],
                                     // fault[178], zero pad
   output logic [0:0]   rsp_tuser,   // result_kind
   // configuration port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [sv39_ptw_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   // input stage
   logic                               in_valid_ff;
   logic                               in_kind_ff;
   sv39_ptw_pkg::req_data_type         in_data_ff;

   // walk state
   logic                               busy_ff, busy_in;
   logic [1:0]                         level_ff, level_in;
   logic [sv39_ptw_pkg::VaWidth-1:0]   vaddr_ff, vaddr_in;
   logic [sv39_ptw_pkg::PpnWidth-1:0]  table_ppn_ff, table_ppn_in;
   logic [sv39_ptw_pkg::PpnWidth-1:0]  root_ppn_ff;

   // result stage
   logic                               out_valid_ff, out_valid_in;
   logic                               out_kind_ff, out_kind_in;
   sv39_ptw_pkg::rsp_data_type         out_data_ff, out_data_in;

   logic                               advance;
   logic                               emit;
   logic                               csr_write;
   logic [sv39_ptw_pkg::PteWidth-1:0]  pte;
   logic [sv39_ptw_pkg::PpnWidth-1:0]  pte_ppn;

   // Move the held transaction on once the result slot is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Configuration access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[3] == sv39_ptw_pkg::CsrRootTablePpn);

   always_comb begin
      if (csr_paddr[3] == sv39_ptw_pkg::CsrRootTablePpn) begin
         csr_prdata = {20'd0, root_ppn_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ppn_ff <= '0;
      end else if (csr_write) begin
         root_ppn_ff <= csr_pwdata[sv39_ptw_pkg::PpnWidth-1:0];
      end
   end

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser[0];
         in_data_ff <= req_tdata;
      end
   end

   assign pte     = in_data_ff.entry_data;
   assign pte_ppn = pte[sv39_ptw_pkg::PpnLsb +: sv39_ptw_pkg::PpnWidth];

   // Decide one step of the walk
   always_comb begin
      busy_in      = busy_ff;
      level_in     = level_ff;
      vaddr_in     = vaddr_ff;
      table_ppn_in = table_ppn_ff;
      emit         = 1'b0;
      out_kind_in  = sv39_ptw_pkg::ResultRead;
      out_data_in  = '0;

      if (advance) begin
         if (in_kind_ff == sv39_ptw_pkg::KindTranslate) begin
            // start a walk at the root table; ignore while busy
            if (!busy_ff) begin
               emit         = 1'b1;
               busy_in      = 1'b1;
               level_in     = sv39_ptw_pkg::LevelGiga;
               vaddr_in     = in_data_ff.virtual_address;
               table_ppn_in = root_ppn_ff;
               out_data_in.read_address = sv39_ptw_pkg::entry_address(
                  root_ppn_ff, in_data_ff.virtual_address, sv39_ptw_pkg::LevelGiga);
            end
         end else if (busy_ff) begin
            emit = 1'b1;
            if (!pte[sv39_ptw_pkg::PteBitV]) begin
               // invalid entry ends the walk
               out_kind_in            = sv39_ptw_pkg::ResultDone;
               out_data_in.leaf_level = level_ff;
               out_data_in.fault      = 1'b1;
               busy_in                = 1'b0;
            end else if (pte[sv39_ptw_pkg::PteBitR] || pte[sv39_ptw_pkg::PteBitW] ||
                         pte[sv39_ptw_pkg::PteBitX] ||
                         level_ff == sv39_ptw_pkg::LevelPage) begin
               // leaf: report translated address and entry
               out_kind_in                  = sv39_ptw_pkg::ResultDone;
               out_data_in.physical_address =
                  sv39_ptw_pkg::leaf_address(pte_ppn, vaddr_ff, level_ff);
               out_data_in.leaf_entry       = pte;
               out_data_in.leaf_level       = level_ff;
               busy_in                      = 1'b0;
            end else begin
               // descend one level
               table_ppn_in = pte_ppn;
               level_in     = level_ff - 2'd1;
               out_data_in.read_address = sv39_ptw_pkg::entry_address(
                  pte_ppn, vaddr_ff, level_ff - 2'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         level_ff     <= sv39_ptw_pkg::LevelGiga;
         vaddr_ff     <= '0;
         table_ppn_ff <= '0;
      end else begin
         busy_ff      <= busy_in;
         level_ff     <= level_in;
         vaddr_ff     <= vaddr_in;
         table_ppn_ff <= table_ppn_in;
      end
   end

   // Result register: load on a new result, drop once taken
   assign out_valid_in = emit || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tuser[0] = out_kind_ff;
   assign rsp_tdata    = out_data_ff;

`ifndef SYNTHESIS
   // Level never leaves the three Sv39 levels
   assert property (@(posedge clock) disable iff (reset) level_ff != 2'd3)
      else $error("walk level out of range");

   // A stalled result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !emit)
      else $error("result overwritten while stalled");

   // Starting a walk leaves the walker busy
   assert property (@(posedge clock) disable iff (reset)
      advance && in_kind_ff == sv39_ptw_pkg::KindTranslate && !busy_ff |=> busy_ff)
      else $error("walk did not start");

   // A finished result leaves the walker idle
   assert property (@(posedge clock) disable iff (reset)
      emit && out_kind_in == sv39_ptw_pkg::ResultDone |=> !busy_ff)
      else $error("walker busy after finish");

   // Only a busy walker reports a finished translation
   assert property (@(posedge clock) disable iff (reset)
      emit && out_kind_in == sv39_ptw_pkg::ResultDone |-> busy_ff)
      else $error("finish reported while idle");
`endif

endmodule

[dv/sv39_page_table_walker_checker.sv]
module sv39_page_table_walker_checker
   import sv39_ptw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,   // virtual_address, entry_data, zero pad
   input  logic [0:0]   req_tuser,   // kind
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [183:0] rsp_tdata,   // read_address, physical_address, leaf_entry,
                                     // leaf_level, fault, zero pad
   input  logic [0:0]   rsp_tuser,   // result_kind
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [63:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           mismatch_count,
   output int           pending_count
);

   typedef struct packed {
      logic         kind;
      rsp_data_type data;
   } walk_result_type;

   // Walker mirror: register, walk progress and the results still owed
   logic [PpnWidth-1:0] root_ppn;
   logic                walking;
   logic [1:0]          cur_level;
   logic [VaWidth-1:0]  cur_vaddr;
   logic [PpnWidth-1:0] cur_table;
   walk_result_type     owed_results[$];
   int                  errors;

   // Byte address of the entry that the current level indexes
   function automatic logic [PaWidth-1:0] pte_fetch_address();
      int                  shift;
      logic [VpnWidth-1:0] idx;
      shift = PageShift + VpnWidth * int'(cur_level);
      idx   = VpnWidth'(cur_vaddr >> shift);
      return {cur_table, {PageShift{1'b0}}} + PaWidth'({idx, 3'b000});
   endfunction

   // Step the walk by one transaction; return 1 when it owes a result
   function automatic bit advance_walk(input logic kind, input req_data_type item,
                                       output walk_result_type res);
      logic [PteWidth-1:0] pte;
      logic [PpnWidth-1:0] ppn;
      int                  shift;
      logic [PaWidth-1:0]  offset;
      res = '0;
      if (kind == KindTranslate) begin
         if (walking) return 1'b0;
         walking   = 1'b1;
         cur_level = LevelGiga;
         cur_vaddr = item.virtual_address;
         cur_table = root_ppn;
         res.kind  = ResultRead;
         res.data.read_address = pte_fetch_address();
         return 1'b1;
      end
      if (!walking) return 1'b0;
      pte = item.entry_data;
      ppn = pte[PpnLsb +: PpnWidth];
      // Invalid entry ends the walk with a fault at this level
      if (!pte[PteBitV]) begin
         res.kind            = ResultDone;
         res.data.leaf_level = cur_level;
         res.data.fault      = 1'b1;
         walking             = 1'b0;
         return 1'b1;
      end
      // Any permission bit, or the last level, makes a leaf
      if (pte[PteBitX:PteBitR] != '0 || cur_level == LevelPage) begin
         shift  = PageShift + VpnWidth * int'(cur_level);
         offset = ((PaWidth'(1) << shift) - PaWidth'(1)) & PaWidth'(cur_vaddr);
         res.kind                  = ResultDone;
         res.data.physical_address = {ppn, {PageShift{1'b0}}} | offset;
         res.data.leaf_entry       = pte;
         res.data.leaf_level       = cur_level;
         walking                   = 1'b0;
         return 1'b1;
      end
      // Pointer entry: descend one level
      cur_table = ppn;
      cur_level = cur_level - 2'd1;
      res.kind  = ResultRead;
      res.data.read_address = pte_fetch_address();
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Track register writes, compare results, predict from accepted transactions
   always @(posedge clock) begin : monitor
      walk_result_type want;
      walk_result_type got;
      if (reset) begin
         root_ppn  = '0;
         walking   = 1'b0;
         cur_level = LevelGiga;
         cur_vaddr = '0;
         cur_table = '0;
         owed_results.delete();
         errors    = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CsrAddrWidth-1:3] == CsrRootTablePpn) begin
            root_ppn = csr_pwdata[PpnWidth-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser[0];
            got.data = rsp_tdata;
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual kind %h data %h",
                        $time, got.kind, got.data);
               errors++;
            end else begin
               want = owed_results.pop_front();
               check_field("result_kind", 64'(want.kind), 64'(got.kind));
               check_field("read_address", 64'(want.data.read_address),
                           64'(got.data.read_address));
               check_field("physical_address", 64'(want.data.physical_address),
                           64'(got.data.physical_address));
               check_field("leaf_entry", want.data.leaf_entry, got.data.leaf_entry);
               check_field("leaf_level", 64'(want.data.leaf_level),
                           64'(got.data.leaf_level));
               check_field("fault", 64'(want.data.fault), 64'(got.data.fault));
            end
         end
         if (req_tvalid && req_tready) begin
            if (advance_walk(req_tuser[0], req_data_type'(req_tdata), want))
               owed_results.push_back(want);
         end
      end
      pending_count  <= owed_results.size();
      mismatch_count <= errors;
   end

endmodule

[dv/sv39_page_table_walker_top_test.sv]
module sv39_page_table_walker_top_test;
   import sv39_ptw_pkg::*;

   // Register index with nothing behind it
   localparam logic [0:0] CsrSpareIndex = 1'd1;
   localparam int         PhaseCount    = 6;
   localparam int         PhaseItems    = 250;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;   // virtual_address[38:0], entry_data[102:39], zero pad
   logic [0:0]   req_tuser;   // kind
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;   // read_address, physical_address, leaf_entry,
                              // leaf_level, fault, zero pad
   logic [0:0]   rsp_tuser;   // result_kind
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [63:0]  csr_pwdata;
   logic [63:0]  csr_prdata;
   logic         csr_pready;
   int           mismatch_count;
   int           pending_count;
   bit           quiet;
   int           items_sent;

   sv39_page_table_walker_top DUT (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   sv39_page_table_walker_checker walk_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatch_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well past the slowest correct run
   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [VaWidth-1:0] rand_vaddr();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return VaWidth'(rand64());
      endcase
   endfunction

   function automatic logic [PteWidth-1:0] make_entry(input logic valid, input logic [2:0] rwx);
      logic [PteWidth-1:0] pte;
      pte = rand64();
      pte[PteBitV] = valid;
      pte[PteBitX:PteBitR] = rwx;
      return pte;
   endfunction

   // Offer one transaction after a random gap and hold it until accepted
   task automatic send_item(input logic kind, input logic [VaWidth-1:0] va,
                            input logic [PteWidth-1:0] pte);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, pte, va};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic request(input logic [VaWidth-1:0] va);
      send_item(KindTranslate, va, rand64());
   endtask

   task automatic respond(input logic [PteWidth-1:0] pte);
      send_item(KindResponse, VaWidth'(rand64()), pte);
   endtask

   // Hold off the sender until every owed result has come, then let the pipe settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Well-formed walk: request, pointer entries, then a leaf or a fault
   task automatic run_walk();
      int         descents;
      int         ending;
      logic [1:0] level;
      request(rand_vaddr());
      items_sent++;
      if ($urandom_range(0, 7) == 0) request(rand_vaddr());
      descents = $urandom_range(0, 2);
      level    = LevelGiga;
      repeat (descents) begin
         respond(make_entry(1'b1, 3'd0));
         items_sent++;
         level = level - 2'd1;
      end
      ending = $urandom_range(0, 2);
      if (ending == 0)
         respond(make_entry(1'b0, 3'($urandom)));
      else if (ending == 2 && level == LevelPage)
         respond(make_entry(1'b1, 3'd0));
      else
         respond(make_entry(1'b1, 3'($urandom_range(1, 7))));
      items_sent++;
      if ($urandom_range(0, 7) == 0) respond(rand64());
   endtask

   // Broken walk: random entries, closed by an invalid entry whatever the state
   task automatic run_broken_walk();
      request(rand_vaddr());
      items_sent++;
      repeat ($urandom_range(0, 3)) begin
         respond(rand64());
         items_sent++;
      end
      respond(make_entry(1'b0, 3'($urandom)));
      items_sent++;
   endtask

   // Result side: stall at random before each result
   initial begin : result_sink
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int target;
      int guard;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= KindTranslate;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      quiet       = 1'b0;
      items_sent  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: root at reset value
      respond(rand64());                          // response while idle
      request('0);
      request('1);                                // request while busy
      respond(64'hFFFF_FFFF_FFFF_FFFE);           // fault at the top level
      wait_idle();

      // Directed: root at its largest value
      write_csr(CsrRootTablePpn, 64'(44'hFFF_FFFF_FFFF));
      request('1);
      respond(64'hFFFF_FFFF_FFFF_FFFF);           // gigapage, misaligned, upper bits set
      request('1);
      respond(64'h003F_FFFF_FFFF_FC01);           // pointer with all-ones PPN
      respond(64'h0000_0000_0000_0000);           // fault at the middle level
      request(39'h55_5555_5555);
      respond(64'h0000_0000_0000_0001);           // pointer to table zero
      respond(64'h0015_5555_5555_5401);
      respond(64'hFFC0_0000_0000_0001);           // pointer at the last level ends as leaf
      request(39'h2A_AAAA_AAAA);
      respond(64'h002A_AAAA_AAAA_A801);
      respond(64'h0012_3456_789A_BC05);           // write without read, megapage
      request(39'h7F_0000_0FFF);
      respond(64'h0000_0000_0000_0401);
      respond(64'h0000_0000_0000_0801);
      respond(64'h003F_FFFF_FFFF_FC09);           // execute-only 4 KiB page
      respond(rand64());                          // response while idle
      wait_idle();

      // Random phases, each with its own register setting
      for (int phase = 0; phase < PhaseCount; phase++) begin
         wait_idle();
         case (phase)
            0:       write_csr(CsrRootTablePpn, 64'd0);
            1:       write_csr(CsrRootTablePpn, 64'(44'hFFF_FFFF_FFFF));
            2:       write_csr(CsrRootTablePpn, '1);
            3:       write_csr(CsrSpareIndex, rand64());
            default: write_csr(CsrRootTablePpn, rand64());
         endcase
         quiet  = (phase == 2);
         target = items_sent + PhaseItems;
         while (items_sent < target) begin
            if ($urandom_range(0, 19) == 0) quiet = !quiet;
            if ($urandom_range(0, 9) < 8)
               run_walk();
            else
               run_broken_walk();
            if ($urandom_range(0, 49) == 0) wait_idle();
         end
      end

      // Drain: wait for the owed results, with a bound, then let the pipe settle
      req_tvalid <= 1'b0;
      quiet = 1'b0;
      guard = 0;
      @(posedge clock);
      while (pending_count != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[files.f]
src/sv39_ptw_pkg.sv
src/sv39_page_table_walker_top.sv
dv/sv39_page_table_walker_checker.sv
dv/sv39_page_table_walker_top_test.sv
